### rtl/core/tlg_pkg.sv
package tlg_pkg;

    // Grid geometry: a square torus, stored one row per memory word
    localparam int GRID_DIM = 16;
    localparam int ROW_W    = $clog2(GRID_DIM);

    // Life rule counts (B3/S23)
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    // Step sweep: one read per row plus a re-read of the last row, a fill of the
    // row window first and a closing step that writes the last row
    localparam int STEP_LAST = GRID_DIM + 2;
    localparam int CLR_LAST  = GRID_DIM - 1;
    localparam int CNT_W     = $clog2(STEP_LAST + 1);

    typedef logic [GRID_DIM-1:0] t_row_word;
    typedef logic [ROW_W-1:0]    t_row_addr;
    typedef logic [CNT_W-1:0]    t_cnt;
    typedef logic [3:0]          t_nbr_cnt;

    // Request codes carried in the slave tuser
    typedef enum logic [2:0] {
        REQ_READ   = 3'd0,
        REQ_WRITE  = 3'd1,
        REQ_TOGGLE = 3'd2,
        REQ_STEP   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req_type;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_STEP,
        ST_CLEAR,
        ST_DONE
    } t_state;

    // Row memory request: a write port and a registered read port, both usable at once
    typedef struct packed {
        logic      we;
        t_row_addr waddr;
        t_row_word wdata;
        logic      re;
        t_row_addr raddr;
    } t_ram_req;

endpackage

### rtl/core/tlg_row_ram.sv
module tlg_row_ram (
    input  logic              i_clk,
    input  tlg_pkg::t_ram_req i_req,
    output tlg_pkg::t_row_word o_rdata
);
    import tlg_pkg::*;

    t_row_word r_mem [GRID_DIM];
    t_row_word r_rdata;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Read one row, data valid the next cycle
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tlg_row_rule.sv
module tlg_row_rule (
    input  tlg_pkg::t_row_word i_above,
    input  tlg_pkg::t_row_word i_center,
    input  tlg_pkg::t_row_word i_below,
    output tlg_pkg::t_row_word o_next
);
    import tlg_pkg::*;

    // Count the eight neighbors of each column, wrapping at the row ends
    for (genvar c = 0; c < GRID_DIM; c++) begin : g_col
        localparam int L = (c + GRID_DIM - 1) % GRID_DIM;
        localparam int R = (c + 1) % GRID_DIM;
        t_nbr_cnt n_cnt;

        assign n_cnt = t_nbr_cnt'(i_above[L])  + t_nbr_cnt'(i_above[c])
                     + t_nbr_cnt'(i_above[R])  + t_nbr_cnt'(i_center[L])
                     + t_nbr_cnt'(i_center[R]) + t_nbr_cnt'(i_below[L])
                     + t_nbr_cnt'(i_below[c])  + t_nbr_cnt'(i_below[R]);

        // Birth on three, survival on two or three
        assign o_next[c] = (n_cnt == t_nbr_cnt'(BIRTH_COUNT))
                         | (i_center[c] & (n_cnt == t_nbr_cnt'(SURVIVE_COUNT)));
    end

endmodule

### rtl/core/toroidal_life_grid_engine_core.sv
// Toroidal Game of Life engine (B3/S23) on a 16 x 16 grid, with a copy of the
// previous generation. Each slave word is one request and gives exactly one
// master word. Cell read, write and toggle go from acceptance through
// ST_CELL_RD (row read) and ST_CELL_WR (modify and write-back) to the result
// register. A generation step sweeps the current-grid row memory one row per
// cycle, re-reading the last row, keeping a three-row window and writing the
// new row and the old row (into the previous-generation memory) behind the
// read pointer. Clear writes one row of both memories per cycle. After reset
// the block zeroes both memories before s_axis_tready first rises. One
// request is in flight at a time; the result register lets the next request
// be taken while a result still waits on m_axis_tready.
module toroidal_life_grid_engine_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [3:0] col, [7:4] row, [8] value
    input  logic [2:0] s_axis_tuser,   // [2:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] cell_state, [1] previous_state
);
    import tlg_pkg::*;

    t_state    r_state, n_state;
    t_cnt      r_cnt;
    t_req_type r_req;
    t_row_addr r_row;
    t_row_addr r_col;
    logic      r_value;
    logic      r_res_cell, r_res_prev;
    logic      r_out_valid, r_out_cell, r_out_prev;
    t_row_word r_win_prev, r_win_cur, r_row0;

    t_ram_req  live_req, prior_req;
    t_row_word live_rdata, prior_rdata;
    t_row_word rule_below, rule_next;
    logic      accept, out_free, cell_old, cell_new;

    tlg_row_ram u_live_ram (
        .i_clk   (i_clk),
        .i_req   (live_req),
        .o_rdata (live_rdata)
    );

    tlg_row_ram u_prior_ram (
        .i_clk   (i_clk),
        .i_req   (prior_req),
        .o_rdata (prior_rdata)
    );

    // New row from the window; the last row wraps to the saved old row 0
    assign rule_below = (r_cnt == t_cnt'(STEP_LAST)) ? r_row0 : live_rdata;

    tlg_row_rule u_rule (
        .i_above  (r_win_prev),
        .i_center (r_win_cur),
        .i_below  (rule_below),
        .o_next   (rule_next)
    );

    assign out_free = !r_out_valid || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;

    // Cell modify
    assign cell_old = live_rdata[r_col];
    always_comb begin
        unique case (r_req)
            REQ_WRITE:  cell_new = r_value;
            REQ_TOGGLE: cell_new = ~cell_old;
            default:    cell_new = cell_old;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT: begin
                if (r_cnt == t_cnt'(CLR_LAST)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    unique case (t_req_type'(s_axis_tuser))
                        REQ_READ, REQ_WRITE, REQ_TOGGLE: n_state = ST_CELL_RD;
                        REQ_STEP:                        n_state = ST_STEP;
                        REQ_CLEAR:                       n_state = ST_CLEAR;
                        default:                         n_state = ST_DONE;
                    endcase
                end
            end
            ST_CELL_RD: n_state = ST_CELL_WR;
            ST_CELL_WR: n_state = ST_DONE;
            ST_STEP: begin
                if (r_cnt == t_cnt'(STEP_LAST)) n_state = ST_DONE;
            end
            ST_CLEAR: begin
                if (r_cnt == t_cnt'(CLR_LAST)) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs: memory accesses and input ready
    always_comb begin
        live_req      = '0;
        prior_req     = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_INIT, ST_CLEAR: begin
                live_req.we     = 1'b1;
                live_req.waddr  = r_cnt[ROW_W-1:0];
                prior_req.we    = 1'b1;
                prior_req.waddr = r_cnt[ROW_W-1:0];
            end
            ST_CELL_RD: begin
                live_req.re     = 1'b1;
                live_req.raddr  = r_row;
                prior_req.re    = 1'b1;
                prior_req.raddr = r_row;
            end
            ST_CELL_WR: begin
                live_req.we    = 1'b1;
                live_req.waddr = r_row;
                live_req.wdata = live_rdata;
                live_req.wdata[r_col] = cell_new;
            end
            ST_STEP: begin
                // read rows last, 0, 1, ... last; write two rows behind
                live_req.re    = (r_cnt <= t_cnt'(GRID_DIM));
                live_req.raddr = t_row_addr'(r_cnt - t_cnt'(1));
                if (r_cnt >= t_cnt'(3)) begin
                    live_req.we     = 1'b1;
                    live_req.waddr  = t_row_addr'(r_cnt - t_cnt'(3));
                    live_req.wdata  = rule_next;
                    prior_req.we    = 1'b1;
                    prior_req.waddr = t_row_addr'(r_cnt - t_cnt'(3));
                    prior_req.wdata = r_win_cur;
                end
            end
            default: ;
        endcase
    end

    // State, sweep counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT || r_state == ST_STEP || r_state == ST_CLEAR) begin
                r_cnt <= r_cnt + t_cnt'(1);
            end else begin
                r_cnt <= '0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the request, the result and the step row window
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= t_req_type'(s_axis_tuser);
            r_col      <= s_axis_tdata[3:0];
            r_row      <= s_axis_tdata[7:4];
            r_value    <= s_axis_tdata[8];
            r_res_cell <= 1'b0;
            r_res_prev <= 1'b0;
        end
        if (r_state == ST_CELL_WR) begin
            r_res_cell <= cell_new;
            r_res_prev <= prior_rdata[r_col];
        end
        if (r_state == ST_STEP) begin
            if (r_cnt == t_cnt'(1)) begin
                r_win_prev <= live_rdata;
            end else if (r_cnt == t_cnt'(2)) begin
                r_win_cur <= live_rdata;
                r_row0    <= live_rdata;
            end else if (r_cnt >= t_cnt'(3) && r_cnt < t_cnt'(STEP_LAST)) begin
                r_win_prev <= r_win_cur;
                r_win_cur  <= live_rdata;
            end
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_cell <= r_res_cell;
            r_out_prev <= r_res_prev;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_prev, r_out_cell};

endmodule

### test/tlg_result_checker.sv
module tlg_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [3:0] col, [7:4] row, [8] value
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] req_type
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [7:0]  i_m_axis_tdata,   // [0] cell_state, [1] previous_state
    output int          o_fail_count,
    output int          o_pending_count
);
    import tlg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // B3/S23 neighbour counts
    localparam int SURVIVE_LOW = 2;
    localparam int BIRTH_NBRS  = 3;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic prev_state;
        logic cell_state;
    } t_cell_answer;

    // Model grids, indexed [row][col]
    logic [GRID_DIM-1:0] live_grid  [GRID_DIM];
    logic [GRID_DIM-1:0] prior_grid [GRID_DIM];

    t_cell_answer answer_q [$];
    t_cell_answer oldest_answer;
    int           reported;

    // Copy the grid to the prior copy and apply one wrapped B3/S23 generation
    function automatic void advance_generation();
        logic [GRID_DIM-1:0] next_grid [GRID_DIM];
        int r, c, dr, dc, nbrs;
        for (r = 0; r < GRID_DIM; r++) begin
            for (c = 0; c < GRID_DIM; c++) begin
                nbrs = 0;
                for (dr = -1; dr <= 1; dr++) begin
                    for (dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            nbrs += live_grid[(r + dr + GRID_DIM) % GRID_DIM]
                                             [(c + dc + GRID_DIM) % GRID_DIM];
                        end
                    end
                end
                if (live_grid[r][c]) begin
                    next_grid[r][c] = (nbrs == SURVIVE_LOW) || (nbrs == BIRTH_NBRS);
                end else begin
                    next_grid[r][c] = (nbrs == BIRTH_NBRS);
                end
            end
        end
        prior_grid = live_grid;
        live_grid  = next_grid;
    endfunction

    // Apply one request to the model grids and return the answer it earns
    function automatic t_cell_answer apply_request(logic [2:0] code, logic [15:0] word);
        t_cell_answer ans;
        logic [3:0]   col;
        logic [3:0]   row;
        ans = '0;
        col = word[3:0];
        row = word[7:4];
        case (code)
            REQ_READ, REQ_WRITE, REQ_TOGGLE: begin
                if (code == REQ_WRITE) begin
                    live_grid[row][col] = word[8];
                end else if (code == REQ_TOGGLE) begin
                    live_grid[row][col] = ~live_grid[row][col];
                end
                ans.cell_state = live_grid[row][col];
                ans.prev_state = prior_grid[row][col];
            end
            REQ_STEP: begin
                advance_generation();
            end
            REQ_CLEAR: begin
                foreach (live_grid[i]) begin
                    live_grid[i]  = '0;
                    prior_grid[i] = '0;
                end
            end
            default: begin
            end
        endcase
        return ans;
    endfunction

    initial begin
        foreach (live_grid[i]) begin
            live_grid[i]  = '0;
            prior_grid[i] = '0;
        end
        o_fail_count    = 0;
        o_pending_count = 0;
        reported        = 0;
    end

    // Check result words first, then queue the answer for an accepted request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (answer_q.size() == 0) begin
                    o_fail_count++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("%0t: result word %h with no request pending",
                                 $realtime, i_m_axis_tdata);
                    end
                end else begin
                    oldest_answer = answer_q.pop_front();
                    if (i_m_axis_tdata[0] !== oldest_answer.cell_state ||
                        i_m_axis_tdata[1] !== oldest_answer.prev_state) begin
                        o_fail_count++;
                        if (reported < REPORT_MAX) begin
                            reported++;
                            $display("%0t: cell_state exp %b got %b, previous_state exp %b got %b",
                                     $realtime, oldest_answer.cell_state, i_m_axis_tdata[0],
                                     oldest_answer.prev_state, i_m_axis_tdata[1]);
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                answer_q.push_back(apply_request(i_s_axis_tuser, i_s_axis_tdata));
            end
            o_pending_count = answer_q.size();
        end
    end

endmodule

### test/tb.sv
module tb;
    import tlg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Top of the 3-bit request code space; codes above clear do nothing
    localparam logic [2:0] REQ_CODE_TOP = 3'd7;
    localparam int         PHASE_ITEMS  = 475;
    localparam int         DRAIN_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [3:0] col, [7:4] row, [8] value
    logic [2:0]  s_axis_tuser = '0;   // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [0] cell_state, [1] previous_state

    int fail_count;
    int pending_count;
    int idle_pct  = 0;
    int stall_pct = 0;

    int phase_idle  [4] = '{0, 77, 0, 11};
    int phase_stall [4] = '{0, 0, 77, 11};

    toroidal_life_grid_engine_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    tlg_result_checker checker_u (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .i_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .i_s_axis_tuser (s_axis_tuser),
        .i_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .i_m_axis_tdata (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending_count(pending_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at the current phase's rate
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Offer one request word after random idle cycles; return at the next falling edge
    task automatic send_request(input logic [2:0] code, input logic [3:0] col,
                                input logic [3:0] row, input logic value);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {7'b0, value, row, col};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Random request of any code with fully random fields
    task automatic send_any();
        int          pick;
        logic [2:0]  code;
        pick = $urandom_range(0, 99);
        if (pick < 30)      code = REQ_READ;
        else if (pick < 55) code = REQ_WRITE;
        else if (pick < 72) code = REQ_TOGGLE;
        else if (pick < 92) code = REQ_STEP;
        else if (pick < 95) code = REQ_CLEAR;
        else                code = 3'($urandom_range(REQ_CLEAR + 1, REQ_CODE_TOP));
        send_request(code, 4'($urandom), 4'($urandom), 1'($urandom));
    endtask

    // Mostly seed a small patch, evolve it a few generations and probe it
    task automatic run_random(input int n_items);
        int         sent;
        logic [3:0] base_col;
        logic [3:0] base_row;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 60) begin
                base_col = 4'($urandom);
                base_row = 4'($urandom);
                repeat ($urandom_range(3, 8)) begin
                    send_request(REQ_WRITE, base_col + 4'($urandom_range(0, 3)),
                                 base_row + 4'($urandom_range(0, 3)),
                                 1'($urandom_range(0, 3) != 0));
                    sent++;
                end
                repeat ($urandom_range(1, 4)) begin
                    send_request(REQ_STEP, 4'($urandom), 4'($urandom), 1'($urandom));
                    sent++;
                end
                repeat ($urandom_range(2, 5)) begin
                    send_request(($urandom_range(0, 4) == 0) ? REQ_TOGGLE : REQ_READ,
                                 base_col + 4'($urandom_range(0, 4)) - 4'd1,
                                 base_row + 4'($urandom_range(0, 4)) - 4'd1,
                                 1'($urandom));
                    sent++;
                end
            end else begin
                send_any();
                sent++;
            end
        end
    endtask

    // Directed: corners as a wrapped block, wrapped blinker, ignored codes
    task automatic run_directed();
        send_request(REQ_READ,   4'd0,  4'd0,  1'b1);
        send_request(REQ_STEP,   4'd5,  4'd9,  1'b1);
        send_request(REQ_WRITE,  4'd0,  4'd0,  1'b1);
        send_request(REQ_WRITE,  4'd15, 4'd0,  1'b1);
        send_request(REQ_WRITE,  4'd0,  4'd15, 1'b1);
        send_request(REQ_WRITE,  4'd15, 4'd15, 1'b1);
        send_request(REQ_STEP,   4'd15, 4'd15, 1'b0);
        send_request(REQ_READ,   4'd15, 4'd15, 1'b0);
        send_request(REQ_TOGGLE, 4'd15, 4'd15, 1'b1);
        send_request(REQ_STEP,   4'd0,  4'd0,  1'b0);
        send_request(REQ_READ,   4'd15, 4'd15, 1'b0);
        send_request(REQ_READ,   4'd0,  4'd15, 1'b1);
        send_request(REQ_CLEAR,  4'd15, 4'd15, 1'b1);
        send_request(REQ_READ,   4'd0,  4'd0,  1'b0);
        send_request(REQ_WRITE,  4'd15, 4'd7,  1'b1);
        send_request(REQ_WRITE,  4'd0,  4'd7,  1'b1);
        send_request(REQ_WRITE,  4'd1,  4'd7,  1'b1);
        send_request(REQ_STEP,   4'd0,  4'd0,  1'b0);
        send_request(REQ_READ,   4'd0,  4'd6,  1'b0);
        send_request(REQ_READ,   4'd15, 4'd7,  1'b1);
        send_request(3'(REQ_CLEAR + 1), 4'd15, 4'd15, 1'b1);
        send_request(REQ_CODE_TOP,  4'd0,  4'd8,  1'b1);
        send_request(REQ_WRITE,  4'd0,  4'd8,  1'b0);
        send_request(REQ_TOGGLE, 4'd10, 4'd3,  1'b0);
        send_request(REQ_READ,   4'd10, 4'd3,  1'b1);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        run_directed();
        for (int p = 0; p < 4; p++) begin
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            run_random(PHASE_ITEMS);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("toroidal_life_grid_engine_core regression: pass");
        end else begin
            $display("toroidal_life_grid_engine_core regression: fail");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #8ms;
        $display("toroidal_life_grid_engine_core regression: fail");
        $finish;
    end

endmodule
